>>> src/binary_lsd_radix_sorter_unit_defines.svh
// ----------------------------------------------------------------------------
// Radix sorter assertion macros
// Shared property forms for the sorter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BINARY_LSD_RADIX_SORTER_UNIT_DEFINES_SVH
`define BINARY_LSD_RADIX_SORTER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RLSD_ASSERT_IMPL(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (conseq)) else $error(msg);

// next-cycle implication, disabled during reset
`define RLSD_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

>>> src/rlsd_pkg.sv
// ----------------------------------------------------------------------------
// Radix sorter package
// Default sizes, fixed port widths and sequencer state codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlsd_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 16;
    localparam int KEY_PORT_W   = 16;
    localparam int IDX_PORT_W   = 6;

    typedef logic [1:0] t_state;

    localparam t_state ST_LOAD = 2'd0;
    localparam t_state ST_SCAN = 2'd1;
    localparam t_state ST_MOVE = 2'd2;
    localparam t_state ST_EMIT = 2'd3;

endpackage

>>> src/rlsd_ram.sv
// ----------------------------------------------------------------------------
// Radix sorter entry RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlsd_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 22
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/binary_lsd_radix_sorter_unit.sv
// Keys load at one per cycle; after the last key the sort opens with a scan,
// and each pass while not yet sorted adds a move and another scan, for at most
// as many passes as the largest key has bits; results leave through the RAM read
// port, each read issued only once the previous entry is back and the output is free.
// Input throughput is one key per cycle while loading. Reset is synchronous active
// low, clears the sequencer, entry count, read pointer and flags; RAM contents stay undefined.
// ----------------------------------------------------------------------------
// Binary LSD radix sorter
// Loads keys into a RAM bank, sorts them with stable one-bit passes that
// ping-pong between two banks, then streams the entries out in key order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_lsd_radix_sorter_unit #(
    parameter int DEPTH    = rlsd_pkg::DEPTH_DEF,
    parameter int KEY_BITS = rlsd_pkg::KEY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [rlsd_pkg::KEY_PORT_W-1:0] i_key,
    input  logic                            i_last,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [rlsd_pkg::KEY_PORT_W-1:0] o_sorted_key,
    output logic [rlsd_pkg::IDX_PORT_W-1:0] o_source_index,
    output logic                            o_final_res,
    output logic                            o_truncated
);

    import rlsd_pkg::*;

    `include "binary_lsd_radix_sorter_unit_defines.svh"

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EW    = KEY_BITS + IDX_W;
    localparam int BIT_W = $clog2(KEY_BITS + 1);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [KEY_BITS-1:0] r_largest, n_largest;
    logic                r_overflow, n_overflow;
    logic                r_src, n_src;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic [CNT_W-1:0]    r_rd, n_rd;
    logic                r_rd_vld, n_rd_vld;
    logic [CNT_W-1:0]    r_pos, n_pos;
    logic [KEY_BITS-1:0] r_prev_key, n_prev_key;
    logic                r_unsorted, n_unsorted;
    logic [CNT_W-1:0]    r_zcnt, n_zcnt;
    logic [CNT_W-1:0]    r_z, n_z;
    logic [CNT_W-1:0]    r_o, n_o;
    logic                r_out_valid, n_out_valid;
    logic [KEY_BITS-1:0] r_out_key, n_out_key;
    logic [IDX_W-1:0]    r_out_idx, n_out_idx;
    logic                r_out_final, n_out_final;
    logic                r_out_trunc, n_out_trunc;

    logic                in_acc;
    logic                out_acc;
    logic                issue;
    logic                store_ok;
    logic [31:0]         key_wide;
    logic [KEY_BITS-1:0] key_in;
    logic [EW-1:0]       rdata0, rdata1, rd_data;
    logic [KEY_BITS-1:0] rd_key;
    logic [KEY_BITS-1:0] rd_shift;
    logic                rd_bit;
    logic                rd_last;
    logic [KEY_BITS-1:0] remaining;
    logic                stop;
    logic [CNT_W-1:0]    move_pos;
    logic                we0, we1;
    logic [IDX_W-1:0]    waddr0;
    logic [EW-1:0]       wdata0;
    logic [31:0]         out_wide;

    assign in_acc   = i_valid && (r_state == ST_LOAD);
    assign out_acc  = r_out_valid && !i_stall;
    assign store_ok = r_count < CNT_W'(DEPTH);
    assign key_wide = 32'(i_key);
    assign key_in   = key_wide[KEY_BITS-1:0];

    assign rd_data   = r_src ? rdata1 : rdata0;
    assign rd_key    = rd_data[EW-1:IDX_W];
    assign rd_shift  = rd_key >> r_bit;
    assign rd_bit    = rd_shift[0];
    assign rd_last   = r_pos == (r_count - CNT_W'(1));
    assign remaining = r_largest >> r_bit;
    assign stop      = remaining == '0;
    assign move_pos  = rd_bit ? (r_zcnt + r_o) : r_z;

    always_comb begin
        issue = 1'b0;
        case (r_state)
            ST_SCAN, ST_MOVE: begin
                issue = r_rd < r_count;
            end
            ST_EMIT: begin
                issue = (r_rd < r_count) && !r_rd_vld && (!r_out_valid || out_acc);
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    assign we0    = (in_acc && store_ok) ||
                    ((r_state == ST_MOVE) && r_rd_vld && r_src);
    assign we1    = (r_state == ST_MOVE) && r_rd_vld && !r_src;
    assign waddr0 = (r_state == ST_LOAD) ? r_count[IDX_W-1:0] : move_pos[IDX_W-1:0];
    assign wdata0 = (r_state == ST_LOAD) ? {key_in, r_count[IDX_W-1:0]} : rd_data;

    rlsd_ram #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (waddr0),
        .i_wdata (wdata0),
        .i_raddr (r_rd[IDX_W-1:0]),
        .o_rdata (rdata0)
    );

    rlsd_ram #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (move_pos[IDX_W-1:0]),
        .i_wdata (rd_data),
        .i_raddr (r_rd[IDX_W-1:0]),
        .o_rdata (rdata1)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_largest   = r_largest;
        n_overflow  = r_overflow;
        n_src       = r_src;
        n_bit       = r_bit;
        n_rd        = issue ? (r_rd + CNT_W'(1)) : r_rd;
        n_rd_vld    = issue;
        n_pos       = issue ? r_rd : r_pos;
        n_prev_key  = r_prev_key;
        n_unsorted  = r_unsorted;
        n_zcnt      = r_zcnt;
        n_z         = r_z;
        n_o         = r_o;
        n_out_valid = r_out_valid && !out_acc;
        n_out_key   = r_out_key;
        n_out_idx   = r_out_idx;
        n_out_final = r_out_final;
        n_out_trunc = r_out_trunc;

        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (store_ok) begin
                        n_count = r_count + CNT_W'(1);
                        if (key_in > r_largest) begin
                            n_largest = key_in;
                        end
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_last) begin
                        n_state    = ST_SCAN;
                        n_rd       = '0;
                        n_bit      = '0;
                        n_src      = 1'b0;
                        n_unsorted = 1'b0;
                        n_zcnt     = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (r_rd_vld) begin
                    n_prev_key = rd_key;
                    if ((r_pos != '0) && (r_prev_key > rd_key)) begin
                        n_unsorted = 1'b1;
                    end
                    if (!rd_bit) begin
                        n_zcnt = r_zcnt + CNT_W'(1);
                    end
                    if (rd_last) begin
                        n_rd = '0;
                        if (!n_unsorted || stop) begin
                            n_state = ST_EMIT;
                        end else begin
                            n_state = ST_MOVE;
                            n_z     = '0;
                            n_o     = '0;
                        end
                    end
                end
            end
            ST_MOVE: begin
                if (r_rd_vld) begin
                    if (rd_bit) begin
                        n_o = r_o + CNT_W'(1);
                    end else begin
                        n_z = r_z + CNT_W'(1);
                    end
                    if (rd_last) begin
                        n_state    = ST_SCAN;
                        n_src      = !r_src;
                        n_bit      = r_bit + BIT_W'(1);
                        n_rd       = '0;
                        n_unsorted = 1'b0;
                        n_zcnt     = '0;
                    end
                end
            end
            ST_EMIT: begin
                if (r_rd_vld) begin
                    n_out_valid = 1'b1;
                    n_out_key   = rd_key;
                    n_out_idx   = rd_data[IDX_W-1:0];
                    n_out_final = rd_last;
                    n_out_trunc = r_overflow;
                end
                if ((r_rd == r_count) && !r_rd_vld) begin
                    n_state    = ST_LOAD;
                    n_count    = '0;
                    n_largest  = '0;
                    n_overflow = 1'b0;
                    n_src      = 1'b0;
                    n_rd       = '0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_largest   <= '0;
            r_overflow  <= 1'b0;
            r_src       <= 1'b0;
            r_bit       <= '0;
            r_rd        <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_largest   <= n_largest;
            r_overflow  <= n_overflow;
            r_src       <= n_src;
            r_bit       <= n_bit;
            r_rd        <= n_rd;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_prev_key  <= n_prev_key;
        r_unsorted  <= n_unsorted;
        r_zcnt      <= n_zcnt;
        r_z         <= n_z;
        r_o         <= n_o;
        r_out_key   <= n_out_key;
        r_out_idx   <= n_out_idx;
        r_out_final <= n_out_final;
        r_out_trunc <= n_out_trunc;
    end

    assign out_wide       = 32'(r_out_key);
    assign o_stall        = r_state != ST_LOAD;
    assign o_valid        = r_out_valid;
    assign o_sorted_key   = out_wide[KEY_PORT_W-1:0];
    assign o_source_index = IDX_PORT_W'(r_out_idx);
    assign o_final_res    = r_out_final;
    assign o_truncated    = r_out_trunc;

    `RLSD_ASSERT_IMPL(a_no_read_in_load, r_rd_vld, r_state != ST_LOAD, "read data while loading")
    `RLSD_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH), "entry count past depth")
    `RLSD_ASSERT_IMPL(a_move_addr, (r_state == ST_MOVE) && r_rd_vld, move_pos < r_count, "move address past count")
    `RLSD_ASSERT_NEXT(a_final_out, (r_state == ST_EMIT) && r_rd_vld && rd_last, r_out_valid && r_out_final, "final transaction not presented")

endmodule
